// ===== rtl/lneb_pkg.sv =====
// Shared types and constants for the line edit buffer.
// Item structs, key codes, operation kinds and controller/datapath signal groups.
// No dependencies.
package lneb_pkg;

	// Default line store depth; capacity is one less
	localparam int LINE_DEPTH_DEF = 128;

	// Key codes
	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] KEY_EXT_PREFIX = 8'd224;
	localparam logic [7:0] KEY_PRINT_LO = 8'd32;
	localparam logic [7:0] KEY_PRINT_HI = 8'd126;

	// Extended key codes, taken after the prefix
	localparam logic [7:0] EXT_LEFT = 8'd75;
	localparam logic [7:0] EXT_RIGHT = 8'd77;
	localparam logic [7:0] EXT_DELETE = 8'd83;
	localparam logic [7:0] EXT_HOME = 8'd71;
	localparam logic [7:0] EXT_END = 8'd79;
	localparam logic [7:0] EXT_INSERT = 8'd82;

	// Operation kinds found at decode
	localparam logic [1:0] KIND_DIRECT = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_INSERT = 2'd2;
	localparam logic [1:0] KIND_REMOVE = 2'd3;

	typedef struct packed {
		logic       opcode;
		logic [7:0] key_byte;
		logic [6:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [6:0] cursor_pos;
		logic [6:0] line_length;
		logic       overwrite_on;
		logic       line_changed;
		logic       full_flag;
		logic [7:0] read_char;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic decode;
		logic step;
		logic finish;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       more;
	} status_t;

endpackage

// ===== rtl/line_edit_buffer.sv =====
// Line edit buffer top level: one-line character buffer driven by key bytes.
// Instantiates lneb_ctrl and lneb_datapath; uses lneb_pkg.
//
//   channel  direction  payload               handshake
//   in       input      lneb_pkg::in_item_t   in_valid / in_ready
//   out      output     lneb_pkg::out_item_t  out_valid / out_ready
//
// An insert or delete shifts the entries behind the cursor (up to LINE_DEPTH-2); the
// line store walk moves one entry per cycle through its single write port. Other items
// skip the walk. A new item is taken only after the result of the last one is emitted.
// Reset clears cursor, length, mode and prefix; the line store is not cleared.
// A result waits in the output register while the next item is taken in; a stalled
// output holds the following result back, and the input waits until it leaves.
module line_edit_buffer #(
	parameter int LINE_DEPTH = lneb_pkg::LINE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lneb_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lneb_pkg::out_item_t  out_item
);

	lneb_pkg::cmd_t    cmd;
	lneb_pkg::status_t status;

	lneb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lneb_datapath #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_item)
	);

endmodule

// ===== rtl/lneb_ctrl.sv =====
// Controller state machine for the line edit buffer.
// Sequences capture, decode, tail shift, finish and result hand-off; uses lneb_pkg.
module lneb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  lneb_pkg::status_t  status,
	output lneb_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// Output register is free when empty or drained this cycle
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Pick the next state and the command for this cycle
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (status.kind inside {lneb_pkg::KIND_INSERT, lneb_pkg::KIND_REMOVE}) begin
					state_d = ST_STEP;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (!status.more) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the state and hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	out_held_until_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	one_command_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

	no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input ready while an item is in flight");

	emit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted result not presented");
`endif

endmodule

// ===== rtl/lneb_datapath.sv =====
// Datapath for the line edit buffer: line store, cursor, length, mode and result register.
// Driven by lneb_ctrl commands; uses lneb_pkg types and key codes.
module lneb_datapath #(
	parameter int LINE_DEPTH = lneb_pkg::LINE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lneb_pkg::in_item_t   in_item,
	input  lneb_pkg::cmd_t       cmd,
	output lneb_pkg::status_t    status,
	output lneb_pkg::out_item_t  out_item
);

	localparam int PW = $clog2(LINE_DEPTH);
	localparam int CW = (PW > 7) ? PW : 7;
	localparam logic [PW-1:0] CAP = PW'(LINE_DEPTH - 1);

	logic [7:0] line_mem_q [LINE_DEPTH];

	lneb_pkg::in_item_t item_q;
	lneb_pkg::out_item_t out_q;
	logic [PW-1:0] cursor_q;
	logic [PW-1:0] length_q;
	logic          ovr_q;
	logic          prefix_q;
	logic [1:0]    kind_q;
	logic          changed_q;
	logic          hit_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] dst_s1;
	logic          mv_s1;
	logic [7:0]    rdata_q;

	logic [1:0]    kind_d;
	logic [PW-1:0] cur_d;
	logic [PW-1:0] len_d;
	logic          ovr_d;
	logic          pre_d;
	logic          changed_d;
	logic          ovr_wr;
	logic          more;
	logic [PW-1:0] src;
	logic [CW-1:0] idx_w;
	logic          hit;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	logic [CW-1:0] cursor_w;
	logic [CW-1:0] length_w;

	// Decode the held item against the current line state
	always_comb begin
		kind_d = lneb_pkg::KIND_DIRECT;
		cur_d = cursor_q;
		len_d = length_q;
		ovr_d = ovr_q;
		pre_d = prefix_q;
		changed_d = 1'b0;
		ovr_wr = 1'b0;
		if (item_q.opcode) begin
			kind_d = lneb_pkg::KIND_READ;
		end else if (prefix_q) begin
			pre_d = 1'b0;
			case (item_q.key_byte)
				lneb_pkg::EXT_LEFT: begin
					if (cursor_q != '0) cur_d = cursor_q - PW'(1);
				end
				lneb_pkg::EXT_RIGHT: begin
					if (cursor_q < length_q) cur_d = cursor_q + PW'(1);
				end
				lneb_pkg::EXT_DELETE: begin
					if (cursor_q < length_q) kind_d = lneb_pkg::KIND_REMOVE;
				end
				lneb_pkg::EXT_HOME: begin
					cur_d = '0;
				end
				lneb_pkg::EXT_END: begin
					cur_d = length_q;
				end
				lneb_pkg::EXT_INSERT: begin
					ovr_d = ~ovr_q;
				end
				default: begin
				end
			endcase
		end else if (item_q.key_byte == lneb_pkg::KEY_EXT_PREFIX) begin
			pre_d = 1'b1;
		end else if (item_q.key_byte inside
				{[lneb_pkg::KEY_PRINT_LO : lneb_pkg::KEY_PRINT_HI]}) begin
			if (ovr_q && (cursor_q < CAP)) begin
				ovr_wr = 1'b1;
				changed_d = 1'b1;
				cur_d = cursor_q + PW'(1);
				if (cursor_q == length_q) len_d = length_q + PW'(1);
			end else if (length_q < CAP) begin
				kind_d = lneb_pkg::KIND_INSERT;
			end
		end else if (item_q.key_byte == lneb_pkg::KEY_BACKSPACE) begin
			if (cursor_q != '0) begin
				kind_d = lneb_pkg::KIND_REMOVE;
				cur_d = cursor_q - PW'(1);
			end
		end
	end

	// Read index widened to compare with the length
	assign idx_w = CW'(item_q.read_index);
	assign length_w = CW'(length_q);
	assign cursor_w = CW'(cursor_q);
	assign hit = idx_w < length_w;

	// Shift walk: insert moves entries up from the end, remove moves them down
	always_comb begin
		if (kind_q == lneb_pkg::KIND_INSERT) begin
			more = ptr_q > cursor_q;
			src = ptr_q - PW'(1);
		end else begin
			more = ({1'b0, ptr_q} + (PW+1)'(1)) < {1'b0, length_q};
			src = ptr_q + PW'(1);
		end
	end

	assign status.kind = kind_d;
	assign status.more = more;

	// Select the single write port
	always_comb begin
		wr_en = 1'b0;
		wr_addr = cursor_q;
		wr_data = item_q.key_byte;
		if (mv_s1) begin
			wr_en = 1'b1;
			wr_addr = dst_s1;
			wr_data = rdata_q;
		end else if (cmd.decode && ovr_wr) begin
			wr_en = 1'b1;
		end else if (cmd.finish && (kind_q == lneb_pkg::KIND_INSERT)) begin
			wr_en = 1'b1;
		end
	end

	// Select the single read port
	always_comb begin
		rd_en = 1'b0;
		rd_addr = src;
		if (cmd.step && more) begin
			rd_en = 1'b1;
		end else if (cmd.decode && (kind_d == lneb_pkg::KIND_READ)) begin
			rd_en = 1'b1;
			rd_addr = idx_w[PW-1:0];
		end
	end

	// Line store with registered read
	always_ff @(posedge clk) begin
		if (wr_en) line_mem_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= line_mem_q[rd_addr];
	end

	// Line state and shift pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			length_q <= '0;
			ovr_q <= 1'b0;
			prefix_q <= 1'b0;
			mv_s1 <= 1'b0;
			kind_q <= lneb_pkg::KIND_DIRECT;
		end else begin
			if (cmd.decode) begin
				cursor_q <= cur_d;
				length_q <= len_d;
				ovr_q <= ovr_d;
				prefix_q <= pre_d;
				kind_q <= kind_d;
			end
			if (cmd.step) begin
				mv_s1 <= more;
			end
			if (cmd.finish) begin
				if (kind_q == lneb_pkg::KIND_INSERT) begin
					cursor_q <= cursor_q + PW'(1);
					length_q <= length_q + PW'(1);
				end else begin
					length_q <= length_q - PW'(1);
				end
			end
		end
	end

	// Item, walk pointer and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_item;
		if (cmd.decode) begin
			changed_q <= changed_d;
			hit_q <= hit;
			ptr_q <= (kind_d == lneb_pkg::KIND_INSERT) ? length_q : cur_d;
		end
		if (cmd.step) begin
			dst_s1 <= ptr_q;
			if (more) ptr_q <= src;
		end
		if (cmd.finish) changed_q <= 1'b1;
		if (cmd.emit) begin
			out_q.cursor_pos <= cursor_w[6:0];
			out_q.line_length <= length_w[6:0];
			out_q.overwrite_on <= ovr_q;
			out_q.line_changed <= changed_q;
			out_q.full_flag <= (length_q == CAP);
			out_q.read_char <= ((kind_q == lneb_pkg::KIND_READ) && hit_q) ? rdata_q : 8'd0;
		end
	end

	assign out_item = out_q;

`ifndef NO_ASSERTIONS
	cursor_within_line: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= length_q)
		else $error("cursor beyond line length");

	length_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= CAP)
		else $error("line length beyond capacity");

	insert_grows_line: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && (kind_q == lneb_pkg::KIND_INSERT)
		|=> length_q == $past(length_q) + PW'(1))
		else $error("insert did not grow the line");

	no_write_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 |-> !(cmd.decode || cmd.finish))
		else $error("shift write overlaps another store write");
`endif

endmodule
